FILE: hdl/ssd_pkg.sv
package ssd_pkg;

  localparam int ValueWidth = 32;
  localparam int FracBits   = 16;
  localparam int CountWidth = 6;

  localparam logic signed [31:0] ValMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;
  localparam logic signed [31:0] VelLimit = 32'sd655360000;
  localparam logic [19:0] UsPerSec = 20'd1000000;
  localparam logic [16:0] OneQ = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] RegRestDrop  = 3'd0;
  localparam logic [2:0] RegTravel    = 3'd1;
  localparam logic [2:0] RegSpring    = 3'd2;
  localparam logic [2:0] RegDamping   = 3'd3;
  localparam logic [2:0] RegPreload   = 3'd4;
  localparam logic [2:0] RegInvMass   = 3'd5;
  localparam logic [2:0] RegForceGain = 3'd6;

  typedef struct packed {
    logic [30:0]        rest_drop;
    logic [30:0]        travel_length;
    logic [30:0]        spring_rate;
    logic [30:0]        damping_rate;
    logic signed [31:0] preload_force;
    logic [16:0]        inverse_mass;
    logic [30:0]        force_gain;
  } ssd_cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] a;
    logic [30:0]        b;
    logic               use_div;
    logic [19:0]        d;
  } ssd_mdu_req_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) sat_add = s[32] ? ValMin : ValMax;
    else sat_add = s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
    sat_neg = (a == ValMin) ? ValMax : -a;
  endfunction

  function automatic logic signed [31:0] clamp_vel(input logic signed [31:0] a);
    if (a > VelLimit) clamp_vel = VelLimit;
    else if (a < -VelLimit) clamp_vel = -VelLimit;
    else clamp_vel = a;
  endfunction

endpackage

FILE: hdl/suspension_spring_damper_step.sv
// channel  | dir | fields (low bit up)
// s_axis   | in  | wheel_contact[0], traced_length[32:1], step_time_us[52:33]
// m_axis   | out | displacement[30:0], spring_speed[61:31], suspension_force[93:62],
//          |     | surface_force[124:94], touching[125]
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// each multiply runs in the shared bit-serial unit as 31 shift-add steps, and a scale by
// the time step adds a restoring divide.
// reset clears the spring state to zero displacement and velocity.
// a new beat is taken once the previous tick has reached the output register;
// a stalled output holds its beat while the next tick is computed.
module suspension_spring_damper_step
  import ssd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,   // wheel_contact, traced_length, step_time_us
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // displacement, spring_speed, suspension_force,
                                       // surface_force, touching
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  ssd_cfg_t cfg_q;

  logic [30:0] disp;
  logic [30:0] speed;
  logic [31:0] susp;
  logic [30:0] surf;
  logic        touch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_drop     <= '0;
      cfg_q.travel_length <= '0;
      cfg_q.spring_rate   <= '0;
      cfg_q.damping_rate  <= '0;
      cfg_q.preload_force <= '0;
      cfg_q.inverse_mass  <= OneQ;
      cfg_q.force_gain    <= {14'd0, OneQ};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRestDrop:  cfg_q.rest_drop     <= cfg_data_i[30:0];
        RegTravel:    cfg_q.travel_length <= cfg_data_i[30:0];
        RegSpring:    cfg_q.spring_rate   <= cfg_data_i[30:0];
        RegDamping:   cfg_q.damping_rate  <= cfg_data_i[30:0];
        RegPreload:   cfg_q.preload_force <= cfg_data_i;
        RegInvMass:   cfg_q.inverse_mass  <= cfg_data_i[16:0];
        RegForceGain: cfg_q.force_gain    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  ssd_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .contact_i          (s_axis_tdata[0]),
    .length_i           (s_axis_tdata[32:1]),
    .step_us_i          (s_axis_tdata[52:33]),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .displacement_o     (disp),
    .spring_speed_o     (speed),
    .suspension_force_o (susp),
    .surface_force_o    (surf),
    .touching_o         (touch)
  );

  assign m_axis_tdata = {2'b00, touch, surf, susp, speed, disp};

endmodule

FILE: hdl/ssd_mdu.sv
module ssd_mdu
  import ssd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssd_mdu_req_t        req_i,
  output logic                done_o,
  output logic signed [31:0]  result_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_OUT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  div_q, div_d;
  logic [31:0]           ua_q, ua_d;
  logic [19:0]           dv_q, dv_d;
  logic [19:0]           rem_q, rem_d;
  logic [62:0]           prod_q, prod_d;

  logic [32:0] mul_sum;
  logic [20:0] trial;
  logic [20:0] diff;
  logic [62:0] quo;
  logic [31:0] lim;
  logic [31:0] qs;

  // product kept as {hi, lo}; lo holds the multiplier bits still to go
  assign mul_sum = {1'b0, prod_q[62:31]} + {1'b0, (prod_q[0] ? ua_q : 32'd0)};
  assign trial   = {rem_q, prod_q[62]};
  assign diff    = trial - {1'b0, dv_q};

  always_comb begin
    quo = div_q ? prod_q : (prod_q >> FracBits);
    lim = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    qs  = (quo > {31'd0, lim}) ? lim : quo[31:0];
    result_o = neg_q ? -qs : qs;
  end

  assign done_o = (state_q == M_OUT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    div_d   = div_q;
    ua_d    = ua_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    prod_d  = prod_q;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.a[31];
          ua_d    = req_i.a[31] ? 32'(-req_i.a) : req_i.a;
          div_d   = req_i.use_div;
          dv_d    = req_i.d;
          prod_d  = {32'd0, req_i.b};
          cnt_d   = '0;
          state_d = M_MUL;
        end
      end
      M_MUL: begin
        prod_d = {mul_sum, prod_q[30:1]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CountWidth'(30)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = div_q ? M_DIV : M_OUT;
        end
      end
      M_DIV: begin
        if (!diff[20]) begin
          rem_d  = diff[19:0];
          prod_d = {prod_q[61:0], 1'b1};
        end else begin
          rem_d  = trial[19:0];
          prod_d = {prod_q[61:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CountWidth'(62)) state_d = M_OUT;
      end
      M_OUT: state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    div_q  <= div_d;
    ua_q   <= ua_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
  end

endmodule

FILE: hdl/ssd_core.sv
module ssd_core
  import ssd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssd_cfg_t      cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          contact_i,
  input  logic [31:0]   length_i,
  input  logic [19:0]   step_us_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [30:0]   displacement_o,
  output logic [30:0]   spring_speed_o,
  output logic [31:0]   suspension_force_o,
  output logic [30:0]   surface_force_o,
  output logic          touching_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  localparam logic [3:0] OP_TVEL   = 4'd0;
  localparam logic [3:0] OP_EXT    = 4'd1;
  localparam logic [3:0] OP_DAMP   = 4'd2;
  localparam logic [3:0] OP_ACC    = 4'd3;
  localparam logic [3:0] OP_VEL    = 4'd4;
  localparam logic [3:0] OP_POS    = 4'd5;
  localparam logic [3:0] OP_STIFF  = 4'd6;
  localparam logic [3:0] OP_DFORCE = 4'd7;
  localparam logic [3:0] OP_SURF   = 4'd8;

  logic [2:0]         state_q, state_d;
  logic [3:0]         op_q, op_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] sp_q, sp_d;
  logic signed [31:0] prev_q, prev_d;
  logic signed [31:0] vel_q, vel_d;

  logic               contact_q, contact_d;
  logic [31:0]        len_q, len_d;
  logic [19:0]        us_q, us_d;
  logic [30:0]        geo_q, geo_d;
  logic               touch_q, touch_d;
  logic signed [31:0] acc_q, acc_d;
  logic signed [31:0] susp_q, susp_d;
  logic [30:0]        surf_q, surf_d;

  logic [30:0]        disp_out_q, disp_out_d;
  logic [30:0]        speed_out_q, speed_out_d;
  logic [31:0]        susp_out_q, susp_out_d;
  logic [30:0]        surf_out_q, surf_out_d;
  logic               touch_out_q, touch_out_d;

  ssd_mdu_req_t       req;
  logic               mdu_done;
  logic signed [31:0] mdu_res;

  logic [30:0]        len_pos;
  logic [16:0]        im_eff;
  logic signed [31:0] rest_s, travel_s;
  logic signed [31:0] vel_new, pos_new, susp_new;
  logic               force_on;

  ssd_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .done_o   (mdu_done),
    .result_o (mdu_res)
  );

  assign len_pos  = len_q[31] ? 31'd0 : len_q[30:0];
  assign im_eff   = (cfg_i.inverse_mass > OneQ) ? OneQ : cfg_i.inverse_mass;
  assign rest_s   = {1'b0, cfg_i.rest_drop};
  assign travel_s = {1'b0, cfg_i.travel_length};
  assign force_on = contact_q && (geo_q != 31'd0);

  // operand select for the shared multiply/divide unit
  always_comb begin
    req.start   = (state_q == ST_START);
    req.a       = '0;
    req.b       = '0;
    req.use_div = 1'b0;
    req.d       = us_q;
    unique case (op_q)
      OP_TVEL: begin
        req.a       = {1'b0, geo_q} - prev_q;
        req.b       = {11'd0, UsPerSec};
        req.use_div = 1'b1;
      end
      OP_EXT: begin
        req.a = sp_q - rest_s;
        req.b = cfg_i.spring_rate;
      end
      OP_DAMP: begin
        req.a = vel_q;
        req.b = cfg_i.damping_rate;
      end
      OP_ACC: begin
        req.a = acc_q;
        req.b = {14'd0, im_eff};
      end
      OP_VEL: begin
        req.a       = acc_q;
        req.b       = {11'd0, us_q};
        req.use_div = 1'b1;
        req.d       = UsPerSec;
      end
      OP_POS: begin
        req.a       = vel_q;
        req.b       = {11'd0, us_q};
        req.use_div = 1'b1;
        req.d       = UsPerSec;
      end
      OP_STIFF: begin
        req.a = {1'b0, geo_q};
        req.b = cfg_i.spring_rate;
      end
      OP_DFORCE: begin
        req.a = -vel_q;
        req.b = cfg_i.damping_rate;
      end
      OP_SURF: begin
        req.a = susp_q;
        req.b = cfg_i.force_gain;
      end
      default: req.a = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    sp_d        = sp_q;
    prev_d      = prev_q;
    vel_d       = vel_q;
    contact_d   = contact_q;
    len_d       = len_q;
    us_d        = us_q;
    geo_d       = geo_q;
    touch_d     = touch_q;
    acc_d       = acc_q;
    susp_d      = susp_q;
    surf_d      = surf_q;
    disp_out_d  = disp_out_q;
    speed_out_d = speed_out_q;
    susp_out_d  = susp_out_q;
    surf_out_d  = surf_out_q;
    touch_out_d = touch_out_q;
    vel_new     = clamp_vel(sat_add(vel_q, mdu_res));
    pos_new     = sat_add(sp_q, mdu_res);
    susp_new    = sat_add(acc_q, sat_neg(mdu_res));

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          contact_d = contact_i;
          len_d     = length_i;
          us_d      = (step_us_i == 20'd0) ? 20'd1 : step_us_i;
          state_d   = ST_PREP;
        end
      end
      ST_PREP: begin
        geo_d   = (len_pos > cfg_i.travel_length) ? 31'd0 : cfg_i.travel_length - len_pos;
        touch_d = contact_q && (geo_d >= cfg_i.rest_drop);
        susp_d  = '0;
        surf_d  = '0;
        op_d    = touch_d ? OP_TVEL : OP_EXT;
        state_d = ST_START;
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mdu_done) begin
          state_d = ST_START;
          case (op_q)
            OP_TVEL: begin
              sp_d    = {1'b0, geo_q};
              prev_d  = {1'b0, geo_q};
              vel_d   = clamp_vel(mdu_res);
              op_d    = OP_STIFF;
              if (!force_on) state_d = ST_HOLD;
            end
            OP_EXT: begin
              acc_d = sat_add(mdu_res, cfg_i.preload_force);
              op_d  = OP_DAMP;
            end
            OP_DAMP: begin
              acc_d = sat_neg(sat_add(acc_q, mdu_res));
              op_d  = OP_ACC;
            end
            OP_ACC: begin
              acc_d = mdu_res;
              op_d  = OP_VEL;
            end
            OP_VEL: begin
              vel_d = vel_new;
              op_d  = OP_POS;
            end
            OP_POS: begin
              // hard stops, lower stop first
              if (pos_new <= rest_s) begin
                sp_d = rest_s;
                if (vel_q < 0) vel_d = '0;
              end else if (pos_new >= travel_s) begin
                sp_d = travel_s;
                if (vel_q > 0) vel_d = '0;
              end else begin
                sp_d = pos_new;
              end
              prev_d = sp_d;
              op_d   = OP_STIFF;
              if (!force_on) state_d = ST_HOLD;
            end
            OP_STIFF: begin
              acc_d = mdu_res;
              op_d  = OP_DFORCE;
            end
            OP_DFORCE: begin
              susp_d = susp_new;
              op_d   = OP_SURF;
              if (susp_new <= 0) state_d = ST_HOLD;
            end
            OP_SURF: begin
              surf_d  = mdu_res[30:0];
              state_d = ST_HOLD;
            end
            default: state_d = ST_HOLD;
          endcase
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          disp_out_d  = sp_q[30:0];
          speed_out_d = 31'(-vel_q);
          susp_out_d  = susp_q;
          surf_out_d  = surf_q;
          touch_out_d = touch_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_TVEL;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      prev_q      <= '0;
      vel_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      sp_q        <= sp_d;
      prev_q      <= prev_d;
      vel_q       <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    contact_q   <= contact_d;
    len_q       <= len_d;
    us_q        <= us_d;
    geo_q       <= geo_d;
    touch_q     <= touch_d;
    acc_q       <= acc_d;
    susp_q      <= susp_d;
    surf_q      <= surf_d;
    disp_out_q  <= disp_out_d;
    speed_out_q <= speed_out_d;
    susp_out_q  <= susp_out_d;
    surf_out_q  <= surf_out_d;
    touch_out_q <= touch_out_d;
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign displacement_o     = disp_out_q;
  assign spring_speed_o     = speed_out_q;
  assign suspension_force_o = susp_out_q;
  assign surface_force_o    = surf_out_q;
  assign touching_o         = touch_out_q;

  // position stays between the stops, so never negative
  a_pos_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni) !sp_q[31])
    else $error("spring position negative");

  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vel_q <= VelLimit) && (vel_q >= -VelLimit))
    else $error("velocity outside bound");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == ST_WAIT))
    else $error("arithmetic result with no pending operation");

  a_start_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |=> (state_q == ST_WAIT) && !mdu_done)
    else $error("operation start not followed by wait");

endmodule
